### hdl/pls_pkg.sv
`default_nettype none

package pls_pkg;

    // Command codes carried by an input transaction
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } t_cell_op;

    // Width of the position field
    localparam int unsigned POS_W = 5;

    // Cell control bundle: operation and 0-based target index
    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   pos_idx;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hdl/pls_cell.sv
`default_nettype none

module pls_cell #(
    parameter int unsigned INDEX = 0
) (
    input  wire                 i_clk,
    input  pls_pkg::t_cell_ctl  i_ctl,
    input  wire  [31:0]         i_item_value,
    input  wire  [31:0]         i_left_data,
    input  wire  [31:0]         i_right_data,
    output logic [31:0]         o_data
);

    localparam logic [31:0] CELL_IDX = 32'(INDEX);

    logic [31:0] r_data;
    logic [31:0] n_data;
    logic [31:0] w_pos;

    assign w_pos = 32'(i_ctl.pos_idx);

    // Pick new content: hold, take the new value, or shift from a neighbor
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            pls_pkg::CELL_INSERT: begin
                if (CELL_IDX > w_pos) begin
                    n_data = i_left_data;
                end else if (CELL_IDX == w_pos) begin
                    n_data = i_item_value;
                end
            end
            pls_pkg::CELL_DELETE: begin
                if (CELL_IDX >= w_pos) begin
                    n_data = i_right_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### hdl/positional_list_store_core.sv
// Positional list store: ordered list of up to CAPACITY signed 32-bit entries.
// An accepted command's result is loaded into the output register. Throughput: one
// command per cycle unless stalled; every cell shifts in parallel in the same cycle.
// Reset (synchronous, active low) empties the list and drops any pending result;
// cell contents are not cleared and are only ever read after an insert writes them.
`default_nettype none

module positional_list_store_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  wire  [1:0]   i_cmd,
    input  wire  [4:0]   i_position,
    input  wire  [31:0]  i_item_value,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output logic [31:0]  o_read_value,
    output logic [1:0]   o_status,
    output logic [4:0]   o_count
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned MW = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;
    // Only cells reachable by a 5-bit position feed the read select
    localparam int unsigned NR = (CAPACITY < 31) ? CAPACITY : 31;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic [31:0]            r_out_read_value;
    pls_pkg::t_status       r_out_status;
    logic [4:0]             r_out_count;

    logic                   w_in_acc;
    pls_pkg::t_cmd          w_cmd;
    logic [MW-1:0]          w_pos;
    logic [MW-1:0]          w_cnt;
    logic                   w_pos_nz;
    logic                   w_full;
    pls_pkg::t_status       w_status;
    logic                   w_rd_ok;
    logic [31:0]            w_rd_sel;
    logic [31:0]            w_rd_value;
    logic [MW-1:0]          w_new_cnt;
    pls_pkg::t_cell_ctl     w_ctl;
    logic [31:0]            w_data [CAPACITY];

    // Accept while the output register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_cmd    = pls_pkg::t_cmd'(i_cmd);
    assign w_pos    = MW'(i_position);
    assign w_cnt    = MW'(r_count);
    assign w_pos_nz = (i_position != '0);
    assign w_full   = (w_cnt == MW'(CAPACITY));

    // Check position, decide status, next count and cell operation
    always_comb begin
        w_status      = pls_pkg::ST_OK;
        w_rd_ok       = 1'b0;
        n_count       = r_count;
        w_ctl.op      = pls_pkg::CELL_HOLD;
        w_ctl.pos_idx = i_position - 5'd1;
        case (w_cmd)
            pls_pkg::CMD_INSERT: begin
                if (!w_pos_nz || (w_pos > w_cnt + MW'(1))) begin
                    w_status = pls_pkg::ST_BAD_POS;
                end else if (w_full) begin
                    w_status = pls_pkg::ST_FULL;
                end else begin
                    w_ctl.op = pls_pkg::CELL_INSERT;
                    n_count  = r_count + CW'(1);
                end
            end
            pls_pkg::CMD_DELETE: begin
                if (!w_pos_nz || (w_pos > w_cnt)) begin
                    w_status = pls_pkg::ST_BAD_POS;
                end else begin
                    w_ctl.op = pls_pkg::CELL_DELETE;
                    n_count  = r_count - CW'(1);
                end
            end
            pls_pkg::CMD_READ: begin
                if (!w_pos_nz || (w_pos > w_cnt)) begin
                    w_status = pls_pkg::ST_BAD_POS;
                end else begin
                    w_rd_ok = 1'b1;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
        if (!w_in_acc) begin
            w_ctl.op = pls_pkg::CELL_HOLD;
            n_count  = r_count;
        end
    end

    // Chain of cells; each neighbor feeds the shift in either direction
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_data[g];
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        pls_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_item_value (i_item_value),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .o_data       (w_data[g])
        );
    end

    // Select the addressed cell for a read (AND-OR over reachable cells)
    always_comb begin
        w_rd_sel = '0;
        for (int k = 0; k < NR; k++) begin
            if (w_ctl.pos_idx == 5'(k)) begin
                w_rd_sel = w_rd_sel | w_data[k];
            end
        end
    end

    assign w_rd_value = w_rd_ok ? w_rd_sel : '0;
    assign w_new_cnt  = MW'(n_count);

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Output register valid: set on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_read_value <= w_rd_value;
            r_out_status     <= w_status;
            r_out_count      <= w_new_cnt[4:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_read_value;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_cmd == pls_pkg::CMD_INSERT && w_status == pls_pkg::ST_OK)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("successful insert did not grow the list");

    a_error_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_status != pls_pkg::ST_OK) |=> (r_count == $past(r_count)))
        else $error("failed transaction changed the list length");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_cmd == pls_pkg::CMD_CLEAR) |=> (r_count == '0 && o_count == 5'd0))
        else $error("clear did not empty the list");
`endif

endmodule

`default_nettype wire
